/* rtl/evs_pkg.sv */
// Shared widths, constants, register codes and request structs for the
// encoder velocity estimator. No dependencies.
package evs_pkg;

  localparam int unsigned Motors   = 2;
  localparam int unsigned MotorW   = 1;
  localparam int unsigned CountW   = 32;
  localparam int unsigned DtW      = 20;
  localparam int unsigned CprW     = 16;
  localparam int unsigned TauW     = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CprW-1:0] CprReset = 16'd1024;

  // Two pi in Q29 times one million, so that microseconds turn into seconds.
  localparam int unsigned    KW       = 52;
  localparam logic [KW-1:0]  TwoPiUs  = 52'd3373259426000000;
  localparam int unsigned    DenShift = 13;

  // Serial multiplier: 32-bit multiplier scanned one bit per cycle.
  localparam int unsigned MulAW  = 32;
  localparam int unsigned MulBW  = 53;
  localparam int unsigned MulHiW = MulBW + 1;
  localparam int unsigned ProdW  = MulBW + MulAW;
  localparam int unsigned MulCntW = 5;

  // Serial divider: one quotient bit per cycle.
  localparam int unsigned DivRemW  = 49;
  localparam int unsigned DivLoW   = 33;
  localparam int unsigned DivQW    = 33;
  localparam int unsigned DivStepW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CPR = 2'd0,
    CFG_TAU = 2'd1,
    CFG_INV = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                start;
    logic [DivRemW-1:0]  rem_init;
    logic [DivLoW-1:0]   num_lo;
    logic [DivStepW-1:0] steps;
    logic [DivRemW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

/* rtl/evs_if.sv */
// Valid/ready channel interfaces for samples in and speed results out.
// Depends on evs_pkg for field widths.
interface evs_in_if import evs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MotorW-1:0]        motor_index;
  logic signed [CountW-1:0] raw_count;
  logic [DtW-1:0]           interval_us;

  modport source(output valid, output motor_index, output raw_count, output interval_us,
                 input ready);
  modport sink(input valid, input motor_index, input raw_count, input interval_us,
               output ready);
endinterface

interface evs_out_if import evs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] signed_count;
  logic signed [CountW-1:0] speed_q16;
  logic                     rejected;

  modport source(output valid, output signed_count, output speed_q16, output rejected,
                 input ready);
  modport sink(input valid, input signed_count, input speed_q16, input rejected,
               output ready);
endinterface

/* rtl/evs_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on evs_pkg.
module evs_mul import evs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mul_req_t         req_i,
  output unit_sts_t        sts_o,
  output logic [ProdW-1:0] prod_o
);

  logic [MulAW-1:0]   a_q;
  logic [MulBW-1:0]   b_q;
  logic [MulHiW-1:0]  hi_q;
  logic [MulAW-1:0]   lo_q;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [MulHiW-1:0]  sum;

  assign sum = hi_q + (a_q[0] ? {1'b0, b_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCntW'(MulAW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a;
      b_q  <= req_i.b;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      a_q  <= a_q >> 1;
      hi_q <= {1'b0, sum[MulHiW-1:1]};
      lo_q <= {sum[0], lo_q[MulAW-1:1]};
    end
  end

  assign prod_o = {hi_q[MulBW-1:0], lo_q};
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

/* rtl/evs_div.sv */
// Restoring divider producing one quotient bit per cycle; the caller
// guarantees the initial remainder is below the divisor. Depends on evs_pkg.
module evs_div import evs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output unit_sts_t        sts_o,
  output logic [DivQW-1:0] quot_o
);

  logic [DivRemW-1:0]  rem_q;
  logic [DivLoW-1:0]   lo_q;
  logic [DivQW-1:0]    quot_q;
  logic [DivRemW-1:0]  den_q;
  logic [DivStepW-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DivRemW:0]    trial;
  logic                fits;
  logic [DivRemW:0]    diff;

  assign trial = {rem_q, lo_q[DivLoW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      lo_q   <= req_i.num_lo;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DivRemW-1:0] : trial[DivRemW-1:0];
      lo_q   <= lo_q << 1;
      quot_q <= {quot_q[DivQW-2:0], fits};
    end
  end

  assign quot_o = quot_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

/* rtl/encoder_velocity_estimator.sv */
// Top level of the encoder velocity estimator: sequencer, per-motor state,
// configuration registers and output register. Depends on evs_pkg, evs_if,
// evs_mul and evs_div.
//
//   Channel   Dir  Handshake          Carries
//   s_in      in   valid/ready        motor_index, raw_count, interval_us
//   m_out     out  valid/ready        signed_count, speed_q16, rejected
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (write only)
//
// A sample with a zero interval skips the arithmetic. Otherwise the serial
// multiplier and divider each take one bit per cycle, a second multiply
// and divide running the low-pass step when the filter is on. All control
// and per-motor state clear on reset. A new sample is taken while the
// previous result waits in the output register.
module encoder_velocity_estimator import evs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  evs_in_if.sink              s_in,
  evs_out_if.source           m_out
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_RAW  = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state_q;
  logic [CprW-1:0]   cpr_q;
  logic [TauW-1:0]   tau_q;
  logic [Motors-1:0] inv_q;
  logic [CountW-1:0] last_q [Motors];
  logic [CountW-1:0] filt_q [Motors];

  logic [MotorW-1:0]  idx_q;
  logic [DtW-1:0]     dt_q;
  logic [DivRemW-1:0] den_q;
  logic               neg_q;
  logic [CountW-1:0]  raw_q;
  logic               dneg_q;

  logic [CountW-1:0] res_count_q;
  logic [CountW-1:0] res_speed_q;
  logic              res_rej_q;

  logic              out_valid_q;
  logic [CountW-1:0] out_count_q;
  logic [CountW-1:0] out_speed_q;
  logic              out_rej_q;

  mul_req_t         mul_req;
  unit_sts_t        mul_sts;
  logic [ProdW-1:0] prod;
  div_req_t         div_req;
  unit_sts_t        div_sts;
  logic [DivQW-1:0] quot;

  logic              in_fire;
  logic              out_free;
  logic [CountW-1:0] now_cnt;
  logic [CountW-1:0] delta;
  logic [CountW-1:0] mag;
  logic [CprW-1:0]   cpr_eff;
  logic [CprW+DtW-1:0] cpr_dt;
  logic              ovf;
  logic [CountW-1:0] qv;
  logic [CountW-1:0] raw_div;
  logic [CountW-1:0] raw_sat;
  logic [CountW-1:0] f_sel;
  logic [CountW:0]   fdiff;
  logic [CountW:0]   fabs;
  logic [DtW:0]      tau_sum;
  logic [CountW+1:0] fstep;
  logic [CountW+1:0] fnew;

  evs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .sts_o  (mul_sts),
    .prod_o (prod)
  );

  evs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quot_o (quot)
  );

  assign s_in.ready = (state_q == S_IDLE);
  assign in_fire    = s_in.valid && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || m_out.ready;

  assign now_cnt = inv_q[s_in.motor_index] ? (CountW'(0) - CountW'(s_in.raw_count))
                                           : CountW'(s_in.raw_count);
  assign delta   = now_cnt - last_q[s_in.motor_index];
  assign mag     = delta[CountW-1] ? (CountW'(0) - delta) : delta;
  assign cpr_eff = (cpr_q == '0) ? CprW'(1) : cpr_q;
  assign cpr_dt  = (CprW+DtW)'(cpr_eff) * (CprW+DtW)'(s_in.interval_us);

  assign ovf = prod[ProdW-2:MulAW] >= (KW)'(den_q);
  assign qv  = quot[CountW-1:0];
  assign raw_sat = neg_q ? {1'b1, {(CountW-1){1'b0}}} : {1'b0, {(CountW-1){1'b1}}};
  always_comb begin
    if (!neg_q) begin
      raw_div = qv[CountW-1] ? raw_sat : qv;
    end else begin
      raw_div = (qv > {1'b1, {(CountW-1){1'b0}}}) ? raw_sat : (CountW'(0) - qv);
    end
  end

  assign f_sel   = filt_q[idx_q];
  assign fdiff   = {raw_q[CountW-1], raw_q} - {f_sel[CountW-1], f_sel};
  assign fabs    = fdiff[CountW] ? ((CountW+1)'(0) - fdiff) : fdiff;
  assign tau_sum = {1'b0, tau_q} + {1'b0, dt_q};
  assign fstep   = dneg_q ? ((CountW+2)'(0) - {1'b0, quot}) : {1'b0, quot};
  assign fnew    = {{2{f_sel[CountW-1]}}, f_sel} + fstep;

  always_comb begin
    mul_req = '0;
    if (in_fire && (s_in.interval_us != '0)) begin
      mul_req.start = 1'b1;
      mul_req.a     = mag;
      mul_req.b     = MulBW'(TwoPiUs);
    end else if ((state_q == S_RAW) && (tau_q != '0)) begin
      mul_req.start = 1'b1;
      mul_req.a     = MulAW'(dt_q);
      mul_req.b     = MulBW'(fabs);
    end
  end

  always_comb begin
    div_req = '0;
    if ((state_q == S_MUL1) && mul_sts.done && !ovf) begin
      div_req.start    = 1'b1;
      div_req.rem_init = prod[MulAW+DivRemW-1:MulAW];
      div_req.num_lo   = {prod[MulAW-1:0], 1'b0};
      div_req.steps    = DivStepW'(MulAW);
      div_req.den      = den_q;
    end else if ((state_q == S_MUL2) && mul_sts.done) begin
      div_req.start    = 1'b1;
      div_req.rem_init = DivRemW'(prod[MulBW-1:DivLoW]);
      div_req.num_lo   = prod[DivLoW-1:0];
      div_req.steps    = DivStepW'(DivQW);
      div_req.den      = DivRemW'(tau_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CprReset;
      tau_q <= '0;
      inv_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CPR: cpr_q <= cfg_data_i[CprW-1:0];
        CFG_TAU: tau_q <= cfg_data_i[TauW-1:0];
        CFG_INV: inv_q <= cfg_data_i[Motors-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int m = 0; m < Motors; m++) begin
        last_q[m] <= '0;
        filt_q[m] <= '0;
      end
    end else begin
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_out.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_in.interval_us == '0) begin
              state_q <= S_FIN;
            end else begin
              last_q[s_in.motor_index] <= now_cnt;
              state_q <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          if (mul_sts.done) begin
            state_q <= ovf ? S_RAW : S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_sts.done) begin
            state_q <= S_RAW;
          end
        end
        S_RAW: begin
          state_q <= (tau_q == '0) ? S_FIN : S_MUL2;
        end
        S_MUL2: begin
          if (mul_sts.done) begin
            state_q <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_sts.done) begin
            filt_q[idx_q] <= fnew[CountW-1:0];
            state_q       <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q       <= s_in.motor_index;
      dt_q        <= s_in.interval_us;
      den_q       <= {cpr_dt, {DenShift{1'b0}}};
      neg_q       <= delta[CountW-1];
      res_count_q <= now_cnt;
      res_speed_q <= '0;
      res_rej_q   <= (s_in.interval_us == '0);
    end
    if ((state_q == S_MUL1) && mul_sts.done && ovf) begin
      raw_q <= raw_sat;
    end
    if ((state_q == S_DIV1) && div_sts.done) begin
      raw_q <= raw_div;
    end
    if (state_q == S_RAW) begin
      res_speed_q <= raw_q;
      dneg_q      <= fdiff[CountW];
    end
    if ((state_q == S_DIV2) && div_sts.done) begin
      res_speed_q <= fnew[CountW-1:0];
    end
    if ((state_q == S_FIN) && out_free) begin
      out_count_q <= res_count_q;
      out_speed_q <= res_speed_q;
      out_rej_q   <= res_rej_q;
    end
  end

  assign m_out.valid        = out_valid_q;
  assign m_out.signed_count = out_count_q;
  assign m_out.speed_q16    = out_speed_q;
  assign m_out.rejected     = out_rej_q;

  // A rejected sample always reports zero speed.
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_out.valid && m_out.rejected) |-> (m_out.speed_q16 == '0))
    else $error("rejected result with nonzero speed");

  // The shared units are never restarted while a request is in flight.
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // No arithmetic is left running when the sequencer is ready for a sample.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
    else $error("arithmetic busy while idle");

endmodule

/* tb/encoder_velocity_estimator_tb.sv */
`timescale 1ns / 100ps
// Testbench for encoder_velocity_estimator: a queue-fed driver, a result monitor and a
// self-contained speed predictor that checks every result field by field.
// Depends on evs_pkg, evs_if and the RTL of the block.
module encoder_velocity_estimator_tb;
  import evs_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandomPerPhase = 240;
  localparam logic [63:0] TwoPiQ29 = 64'hC90FDAA2;
  localparam logic [63:0] UsPerSec = 64'd1000000;

  typedef struct packed {
    logic [MotorW-1:0] motor;
    logic [CountW-1:0] raw;
    logic [DtW-1:0]    dt;
  } sample_t;

  typedef struct packed {
    logic [CountW-1:0] signed_count;
    logic [CountW-1:0] speed;
    logic              rejected;
  } speed_rec_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  evs_in_if  in_if ();
  evs_out_if out_if ();

  encoder_velocity_estimator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_in       (in_if.sink),
    .m_out      (out_if.source)
  );

  sample_t    sample_queue[$];
  speed_rec_t pending_speeds[$];

  logic [CprW-1:0]   cpr_q = CprReset;
  logic [TauW-1:0]   tau_q = '0;
  logic [Motors-1:0] inv_q = '0;
  logic [CountW-1:0] last_cnt [Motors];
  logic [CountW-1:0] filt_speed [Motors];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  logic        in_taken = 1'b0;
  logic        sender_busy = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Sign, delta, M-method speed, saturation and the optional low-pass step.
  function automatic speed_rec_t estimate(input logic [MotorW-1:0] m,
                                          input logic [CountW-1:0] raw,
                                          input logic [DtW-1:0] dt);
    speed_rec_t          r;
    logic [CountW-1:0]   now;
    logic [CountW-1:0]   delta;
    logic [CountW-1:0]   mag;
    logic [CountW-1:0]   spd;
    logic [CprW-1:0]     cpr_eff;
    logic                neg;
    logic [127:0]        num;
    logic [127:0]        den;
    logic [127:0]        quo;
    logic signed [63:0]  f;
    logic signed [63:0]  diff;
    logic signed [63:0]  step;
    logic [63:0]         dmag;
    now = inv_q[m] ? -raw : raw;
    r.signed_count = now;
    r.speed = '0;
    r.rejected = 1'b1;
    if (dt == '0) begin
      return r;
    end
    cpr_eff = (cpr_q == '0) ? 16'd1 : cpr_q;
    delta = now - last_cnt[m];
    neg = delta[31];
    mag = neg ? -delta : delta;
    num = 128'(mag) * 128'(TwoPiQ29) * 128'(UsPerSec);
    den = (128'(cpr_eff) * 128'(dt)) << DenShift;
    quo = num / den;
    if (!neg) begin
      spd = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    end else begin
      spd = (quo > 128'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
    end
    last_cnt[m] = now;
    if (tau_q != '0) begin
      f = {{32{filt_speed[m][31]}}, filt_speed[m]};
      diff = {{32{spd[31]}}, spd} - f;
      dmag = (diff < 0) ? -diff : diff;
      dmag = (dmag * 64'(dt)) / (64'(tau_q) + 64'(dt));
      step = (diff < 0) ? -$signed(dmag) : $signed(dmag);
      filt_speed[m] = 32'(f + step);
      spd = filt_speed[m];
    end
    r.speed = spd;
    r.rejected = 1'b0;
    return r;
  endfunction

  task automatic add_sample(input logic [MotorW-1:0] m, input logic [CountW-1:0] raw,
                            input logic [DtW-1:0] dt);
    sample_t s;
    s.motor = m;
    s.raw = raw;
    s.dt = dt;
    sample_queue.push_back(s);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CPR: cpr_q = val[CprW-1:0];
      CFG_TAU: tau_q = val[TauW-1:0];
      CFG_INV: inv_q = val[Motors-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || sender_busy || pending_speeds.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Request driver: holds a request until it is taken, then pulls the next one; also drives random result stalls.
  always @(negedge clk) begin
    sample_t nxt;
    if (rst_n) begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
      if (!sender_busy || in_taken) begin
        in_taken = 1'b0;
        if (sample_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = sample_queue.pop_front();
          sender_busy = 1'b1;
          in_if.valid <= 1'b1;
          in_if.motor_index <= nxt.motor;
          in_if.raw_count <= nxt.raw;
          in_if.interval_us <= nxt.dt;
        end else begin
          sender_busy = 1'b0;
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    speed_rec_t want;
    logic       active;
    if (rst_n) begin
      active = 1'b0;
      if (out_if.valid && out_if.ready) begin
        active = 1'b1;
        if (pending_speeds.size() == 0) begin
          flag_mismatch("result arrived with no request outstanding");
        end else begin
          want = pending_speeds.pop_front();
          if (out_if.signed_count !== want.signed_count)
            flag_mismatch($sformatf("signed_count %h, predicted %h",
                                    out_if.signed_count, want.signed_count));
          if (out_if.speed_q16 !== want.speed)
            flag_mismatch($sformatf("speed_q16 %h, predicted %h",
                                    out_if.speed_q16, want.speed));
          if (out_if.rejected !== want.rejected)
            flag_mismatch($sformatf("rejected %b, predicted %b",
                                    out_if.rejected, want.rejected));
        end
        results_seen++;
      end
      if (in_if.valid && in_if.ready) begin
        active = 1'b1;
        pending_speeds.push_back(estimate(in_if.motor_index, in_if.raw_count,
                                          in_if.interval_us));
        in_taken = 1'b1;
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [MotorW-1:0] m;
    int unsigned       kind;
    logic [CountW-1:0] track [Motors];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_CPR;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.motor_index = '0;
    in_if.raw_count = '0;
    in_if.interval_us = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < Motors; i++) begin
      last_cnt[i] = '0;
      filt_speed[i] = '0;
      track[i] = $urandom;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_CPR, 20'd1);
          write_reg(CFG_TAU, 20'd0);
          write_reg(CFG_INV, 20'd3);
        end
        2: begin
          write_reg(CFG_CPR, 20'd65535);
          write_reg(CFG_TAU, 20'hFFFFF);
          write_reg(CFG_INV, 20'd1);
        end
        3: begin
          write_reg(CFG_CPR, 20'd0);
          write_reg(CFG_TAU, 20'd1);
          write_reg(CFG_INV, 20'd2);
        end
        default: begin
          write_reg(CFG_CPR, ($urandom_range(3) == 0) ? 20'($urandom_range(16, 1))
                                                     : 20'($urandom_range(65535, 1)));
          write_reg(CFG_TAU, ($urandom_range(2) == 0) ? 20'd0
                                                     : 20'($urandom_range(1000000, 1)));
          write_reg(CFG_INV, 20'($urandom_range(3)));
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase

      case (ph)
        0: begin
          add_sample(1'b0, 32'd0, 20'd1000);
          add_sample(1'b0, 32'd1024, 20'd1000000);
          add_sample(1'b1, -32'sd1024, 20'd1000000);
          add_sample(1'b0, 32'd5000, 20'd0);
          add_sample(1'b0, 32'd2048, 20'hFFFFF);
          add_sample(1'b0, 32'h7FFF_FFFF, 20'd1);
          add_sample(1'b0, 32'h8000_0000, 20'd1);
          add_sample(1'b1, 32'h7FFF_FFFF, 20'd1);
          add_sample(1'b1, 32'hFFFF_FFFF, 20'd1);
        end
        1: begin
          add_sample(1'b0, 32'h8000_0000, 20'd1);
          add_sample(1'b1, 32'd1, 20'hFFFFF);
          add_sample(1'b0, 32'h8000_0000, 20'd0);
          add_sample(1'b1, 32'h7FFF_FFFF, 20'd1);
        end
        2: begin
          add_sample(1'b0, 32'd100000, 20'd1000);
          add_sample(1'b0, 32'd0, 20'd1);
          add_sample(1'b1, 32'h4000_0000, 20'hFFFFF);
        end
        3: begin
          add_sample(1'b0, 32'h7FFF_FFFF, 20'd1);
          add_sample(1'b1, 32'h8000_0000, 20'd1);
          add_sample(1'b0, -32'sd5, 20'hFFFFF);
        end
        default: ;
      endcase

      // Mostly smooth motion per motor, with count jumps, rejected samples and noise.
      for (int i = 0; i < RandomPerPhase; i++) begin
        m = MotorW'($urandom_range(Motors - 1));
        kind = $urandom_range(99);
        if (kind < 70) begin
          track[m] = track[m] + 32'($urandom_range(6000)) - 32'd3000;
          add_sample(m, track[m], 20'($urandom_range(20000, 200)));
        end else if (kind < 75) begin
          add_sample(m, $urandom, 20'd0);
        end else begin
          add_sample(m, $urandom, 20'($urandom_range(20'hFFFFF)));
        end
      end
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* encoder_velocity_estimator.f */
rtl/evs_pkg.sv
rtl/evs_if.sv
rtl/evs_mul.sv
rtl/evs_div.sv
rtl/encoder_velocity_estimator.sv
tb/encoder_velocity_estimator_tb.sv
